FILE: design/ppi_pkg.sv
// Shared types and constants for the particle pool integrator.
// Holds the operation codes, the per-slot record layout and the saturation helpers.
package ppi_pkg;

    localparam int CW   = 7;   // slot counter width, can hold the pool size itself
    localparam int MA_W = 33;  // multiplier operand A
    localparam int MB_W = 22;  // multiplier operand B
    localparam int MP_W = MA_W + MB_W;
    localparam int SUM_W = 57;

    localparam logic [31:0] LIFE_ONE  = 32'h0001_0000;
    localparam logic [7:0]  SIZE_ONE  = 8'd1;
    localparam logic [21:0] FACTOR_ONE = 22'h10_0000;

    typedef enum logic [1:0] {
        OP_EMIT  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [15:0]        drag;
        logic [31:0]        life;
        logic [31:0]        app;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    function automatic logic signed [SUM_W-1:0] sx32(input logic signed [31:0] v);
        return {{(SUM_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [SUM_W-1:0] sxprod(input logic signed [MP_W-1:0] v);
        return {{(SUM_W-MP_W){v[MP_W-1]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        if (v > 57'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -57'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: design/particle_pool_integrator.sv
// Top level of the particle pool integrator: sequencer, slot flags and counters.
// Depends on ppi_pkg, ppi_ram (slot records) and ppi_mul (shared multiplier).
//
// Usage: one input channel (i_in_valid / o_in_stall) carries an operation and
// its operands; one output channel (o_out_valid / i_out_stall) returns exactly
// one result per transaction. The block works on one transaction at a time and
// stalls its input until that transaction has reached the output register.
// Steps per transaction:
//   emit  : flag scan from slot 0 for the lowest free slot, one slot per cycle
//   tick  : scan up to the top mark; per active slot below it a record read,
//           seven multiplies through the one shared multiplier, and a write
//           back; a zero time step goes straight to the result
//   clear : every memory row zeroed, one memory row per cycle
//   read  : one memory read through the registered read port
// The result sits in the output register until taken; while the receiver
// stalls, a finished transaction waits there and the next one is still taken
// in, but its result is held back until the register frees up.
// Reset clears the slot flags, live count and high-water mark; the record
// memory is not cleared by reset.
module particle_pool_integrator #(
    parameter int POOL_SLOTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_acc_x,
    input  logic signed [31:0] i_acc_y,
    input  logic [15:0]        i_drag_rate,
    input  logic [31:0]        i_lifetime,
    input  logic [31:0]        i_appearance,
    input  logic [15:0]        i_time_step,
    input  logic [5:0]         i_slot_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_status,
    output logic [5:0]         o_slot,
    output logic [6:0]         o_alive_count,
    output logic [6:0]         o_high_mark,
    output logic               o_slot_active,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_vel_x,
    output logic signed [31:0] o_out_vel_y,
    output logic [31:0]        o_life_left,
    output logic [31:0]        o_out_appearance
);
    import ppi_pkg::*;

    localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam logic [CW-1:0] LAST = CW'(POOL_SLOTS - 1);
    localparam logic [CW-1:0] NSLOT = CW'(POOL_SLOTS);
    localparam logic [3:0] LAST_STEP = 4'd13;

    typedef enum logic [3:0] {
        S_IDLE, S_EMIT, S_TSCAN, S_TLOAD, S_TMATH, S_TWR,
        S_RADDR, S_RDATA, S_CLR, S_DONE
    } t_state;

    t_state                 r_state;
    logic [POOL_SLOTS-1:0]  r_active;
    logic [CW-1:0]          r_live, r_top, r_newtop, r_idx;
    t_op                    r_op;
    t_rec                   r_spawn, r_rec;
    logic [15:0]            r_dt;
    logic [3:0]             r_step;
    logic [MB_W-1:0]        r_fac;
    logic                   r_status;
    logic [5:0]             r_slot;
    logic                   r_rd_ok, r_rd_act;

    logic                   r_ovalid, r_ostatus, r_oact;
    logic [5:0]             r_oslot;
    logic [6:0]             r_olive, r_otop;
    logic signed [31:0]     r_opx, r_opy, r_ovx, r_ovy;
    logic [31:0]            r_olife, r_oapp;

    logic                   n_we;
    logic [REC_W-1:0]       n_wdata;
    logic [REC_W-1:0]       w_rdata;
    logic signed [MA_W-1:0] n_a;
    logic signed [MB_W-1:0] n_b;
    logic signed [MP_W-1:0] w_prod;
    logic signed [MP_W-1:0] w_sh12, w_sh20;
    logic signed [MB_W-1:0] w_dt_b;
    logic [31:0]            w_dtq;
    logic                   w_accept, w_out_free;
    logic [31:0]            w_app;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_ovalid || !i_out_stall;
    assign w_dt_b     = {6'b0, r_dt};
    assign w_dtq      = {12'b0, r_dt, 4'b0};
    assign w_sh12     = w_prod >>> 12;
    assign w_sh20     = w_prod >>> 20;
    assign w_app      = (i_appearance[23:16] == 8'd0) ?
                        {i_appearance[31:24], SIZE_ONE, i_appearance[15:0]} : i_appearance;

    // Shared multiplier operands, one multiply per pair of steps.
    always_comb begin
        n_a = '0;
        n_b = w_dt_b;
        case (r_step[3:1])
            3'd0: n_a = {r_rec.ax[31], r_rec.ax};
            3'd1: n_a = {r_rec.ay[31], r_rec.ay};
            3'd2: n_a = {17'b0, r_rec.drag};
            3'd3: begin
                n_a = {r_rec.vx[31], r_rec.vx};
                n_b = r_fac;
            end
            3'd4: begin
                n_a = {r_rec.vy[31], r_rec.vy};
                n_b = r_fac;
            end
            3'd5: n_a = {r_rec.vx[31], r_rec.vx};
            3'd6: n_a = {r_rec.vy[31], r_rec.vy};
            default: n_a = '0;
        endcase
    end

    // Memory write port: emit fill, tick write-back, clear sweep.
    always_comb begin
        n_we    = 1'b0;
        n_wdata = '0;
        case (r_state)
            S_EMIT: begin
                n_we    = !r_active[r_idx[AW-1:0]];
                n_wdata = r_spawn;
            end
            S_TWR: begin
                n_we    = 1'b1;
                n_wdata = r_rec;
                if (r_rec.life <= w_dtq) begin
                    n_wdata[31+32:32] = '0;
                end else begin
                    n_wdata[31+32:32] = r_rec.life - w_dtq;
                end
            end
            S_CLR: n_we = 1'b1;
            default: n_we = 1'b0;
        endcase
    end

    ppi_ram #(.W(REC_W), .D(POOL_SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (n_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    ppi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (n_a),
        .i_b    (n_b),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_live   <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= t_op'(i_operation);
                        r_dt     <= i_time_step;
                        r_status <= 1'b0;
                        r_rd_act <= 1'b0;
                        r_newtop <= '0;
                        r_idx    <= (t_op'(i_operation) == OP_READ) ?
                                    {1'b0, i_slot_index} : '0;
                        r_slot   <= (t_op'(i_operation) == OP_READ) ? i_slot_index : '0;
                        r_rd_ok  <= (t_op'(i_operation) == OP_READ) &&
                                    ({1'b0, i_slot_index} < NSLOT);
                        r_spawn  <= '{px: i_pos_x, py: i_pos_y, vx: i_vel_x, vy: i_vel_y,
                                      ax: i_acc_x, ay: i_acc_y, drag: i_drag_rate,
                                      life: (i_lifetime == 32'd0) ? LIFE_ONE : i_lifetime,
                                      app: w_app};
                        case (t_op'(i_operation))
                            OP_EMIT:  r_state <= S_EMIT;
                            OP_TICK:  r_state <= (i_time_step == 16'd0) ? S_DONE : S_TSCAN;
                            OP_CLEAR: begin
                                r_active <= '0;
                                r_live   <= '0;
                                r_top    <= '0;
                                r_state  <= S_CLR;
                            end
                            default: r_state <= S_RADDR;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (!r_active[r_idx[AW-1:0]]) begin
                        r_active[r_idx[AW-1:0]] <= 1'b1;
                        r_live <= r_live + 1'b1;
                        if (r_idx + 1'b1 > r_top) begin
                            r_top <= r_idx + 1'b1;
                        end
                        r_slot  <= r_idx[5:0];
                        r_state <= S_DONE;
                    end else if (r_idx == LAST) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TSCAN: begin
                    if (r_idx >= r_top) begin
                        r_top   <= r_newtop;
                        r_state <= S_DONE;
                    end else if (r_active[r_idx[AW-1:0]]) begin
                        r_state <= S_TLOAD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TLOAD: begin
                    r_rec   <= t_rec'(w_rdata);
                    r_step  <= '0;
                    r_state <= S_TMATH;
                end
                S_TMATH: begin
                    // odd steps consume the product of the step before
                    if (r_step[0]) begin
                        case (r_step[3:1])
                            3'd0: r_rec.vx <= sat32(sx32(r_rec.vx) + sxprod(w_sh12));
                            3'd1: r_rec.vy <= sat32(sx32(r_rec.vy) + sxprod(w_sh12));
                            3'd2: r_fac <= (w_prod >= MP_W'(FACTOR_ONE)) ? '0 :
                                           FACTOR_ONE - {1'b0, w_prod[20:0]};
                            3'd3: if (r_rec.drag != 16'd0) r_rec.vx <= w_sh20[31:0];
                            3'd4: if (r_rec.drag != 16'd0) r_rec.vy <= w_sh20[31:0];
                            3'd5: r_rec.px <= sat32(sx32(r_rec.px) + sxprod(w_sh12));
                            3'd6: r_rec.py <= sat32(sx32(r_rec.py) + sxprod(w_sh12));
                            default: r_fac <= r_fac;
                        endcase
                    end
                    if (r_step == LAST_STEP) begin
                        r_state <= S_TWR;
                    end
                    r_step <= r_step + 1'b1;
                end
                S_TWR: begin
                    if (r_rec.life <= w_dtq) begin
                        r_active[r_idx[AW-1:0]] <= 1'b0;
                        if (r_live != '0) begin
                            r_live <= r_live - 1'b1;
                        end
                    end else begin
                        r_newtop <= r_idx + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_TSCAN;
                end
                S_RADDR: r_state <= S_RDATA;
                S_RDATA: begin
                    r_rec    <= t_rec'(w_rdata);
                    r_rd_act <= r_rd_ok && r_active[r_idx[AW-1:0]];
                    r_state  <= S_DONE;
                end
                S_CLR: begin
                    if (r_idx == LAST) begin
                        r_state <= S_DONE;
                    end
                    r_idx <= r_idx + 1'b1;
                end
                S_DONE: begin
                    // hold the result until the output register frees up
                    if (w_out_free) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_status;
                        r_oslot   <= r_slot;
                        r_olive   <= r_live;
                        r_otop    <= r_top;
                        r_oact    <= (r_op == OP_READ) && r_rd_act;
                        if (r_op == OP_READ && r_rd_ok) begin
                            r_opx   <= r_rec.px;
                            r_opy   <= r_rec.py;
                            r_ovx   <= r_rec.vx;
                            r_ovy   <= r_rec.vy;
                            r_olife <= r_rec.life;
                            r_oapp  <= r_rec.app;
                        end else begin
                            r_opx   <= '0;
                            r_opy   <= '0;
                            r_ovx   <= '0;
                            r_ovy   <= '0;
                            r_olife <= '0;
                            r_oapp  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_slot           = r_oslot;
    assign o_alive_count    = r_olive;
    assign o_high_mark      = r_otop;
    assign o_slot_active    = r_oact;
    assign o_out_pos_x      = r_opx;
    assign o_out_pos_y      = r_opy;
    assign o_out_vel_x      = r_ovx;
    assign o_out_vel_y      = r_ovy;
    assign o_life_left      = r_olife;
    assign o_out_appearance = r_oapp;

    a_live_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_live) == $countones(r_active))
        else $error("live count out of step with slot flags");

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= NSLOT)
        else $error("high-water mark beyond pool");

    a_emit_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_active[r_idx[AW-1:0]]) |=> r_live == $past(r_live) + 1'b1)
        else $error("emit did not bump live count");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> o_out_valid)
        else $error("finished transaction not presented");

endmodule

FILE: design/ppi_ram.sv
// Generic single-write, single-read memory with registered read data.
// No package dependencies.
module ppi_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ppi_mul.sv
// Shared signed multiplier with a registered product.
// Uses the operand widths from ppi_pkg.
module ppi_mul (
    input  logic                             i_clk,
    input  logic signed [ppi_pkg::MA_W-1:0]  i_a,
    input  logic signed [ppi_pkg::MB_W-1:0]  i_b,
    output logic signed [ppi_pkg::MP_W-1:0]  o_prod
);
    import ppi_pkg::*;

    logic signed [MP_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for particle_pool_integrator.
// Depends on ppi_pkg; drives a directed table, then random bursts, against a local predictor.
module testbench;
    import ppi_pkg::*;

    typedef struct {
        t_op                op;
        logic signed [31:0] px, py, vx, vy, ax, ay;
        logic [15:0]        drag;
        logic [31:0]        life;
        logic [31:0]        app;
        logic [15:0]        dt;
        logic [5:0]         idx;
    } t_pool_cmd;

    typedef struct {
        logic        status;
        logic [5:0]  slot;
        logic [6:0]  alive;
        logic [6:0]  high;
        logic        active;
        logic [31:0] px, py, vx, vy, life, app;
    } t_pool_resp;

    typedef struct {
        t_pool_cmd  cmd;
        bit         typed;
        logic       status;
        logic [5:0] slot;
        logic [6:0] alive;
        logic [6:0] high;
    } t_table_row;

    localparam int SLOTS = 64;
    localparam int RANDOM_ITEMS = 1800;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b1;
    logic [1:0] op_w = OP_CLEAR;
    logic signed [31:0] px_w = '0, py_w = '0, vx_w = '0, vy_w = '0, ax_w = '0, ay_w = '0;
    logic [15:0] drag_w = '0;
    logic [31:0] life_w = '0;
    logic [31:0] app_w = '0;
    logic [15:0] dt_w = '0;
    logic [5:0] idx_w = '0;

    logic        in_stall, out_valid, st, act;
    logic [5:0]  slot_o;
    logic [6:0]  alive_o, high_o;
    logic signed [31:0] opx, opy, ovx, ovy;
    logic [31:0] olife, oapp;

    particle_pool_integrator #(.POOL_SLOTS(SLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_operation(op_w),
        .i_pos_x(px_w), .i_pos_y(py_w), .i_vel_x(vx_w), .i_vel_y(vy_w),
        .i_acc_x(ax_w), .i_acc_y(ay_w), .i_drag_rate(drag_w),
        .i_lifetime(life_w), .i_appearance(app_w), .i_time_step(dt_w),
        .i_slot_index(idx_w),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(st), .o_slot(slot_o), .o_alive_count(alive_o), .o_high_mark(high_o),
        .o_slot_active(act), .o_out_pos_x(opx), .o_out_pos_y(opy),
        .o_out_vel_x(ovx), .o_out_vel_y(ovy), .o_life_left(olife),
        .o_out_appearance(oapp)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state
    t_rec pool [SLOTS];
    bit   in_use [SLOTS];
    int   live_cnt;
    int   top;

    t_pool_resp pending_results[$];
    int  fail_cnt = 0;
    bit  calm = 1'b0;
    bit  hold_req = 1'b0;
    bit  inputs_done = 1'b0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic void wipe_pool();
        for (int i = 0; i < SLOTS; i++) begin
            pool[i] = '0;
            in_use[i] = 1'b0;
        end
        live_cnt = 0;
        top = 0;
    endfunction

    function automatic void step_particle(input int i, input longint dt);
        longint vx, vy, dd, factor;
        vx = clamp32(longint'(pool[i].vx) + ((longint'(pool[i].ax) * dt) >>> 12));
        vy = clamp32(longint'(pool[i].vy) + ((longint'(pool[i].ay) * dt) >>> 12));
        if (pool[i].drag != 0) begin
            dd = longint'({1'b0, pool[i].drag}) * dt;
            factor = (dd >= 64'sh10_0000) ? 0 : 64'sh10_0000 - dd;
            vx = (vx * factor) >>> 20;
            vy = (vy * factor) >>> 20;
        end
        pool[i].vx = vx[31:0];
        pool[i].vy = vy[31:0];
        pool[i].px = 32'(clamp32(longint'(pool[i].px) + ((vx * dt) >>> 12)));
        pool[i].py = 32'(clamp32(longint'(pool[i].py) + ((vy * dt) >>> 12)));
    endfunction

    function automatic t_pool_resp predict_pool(input t_pool_cmd c);
        t_pool_resp r;
        int found;
        int new_top;
        longint dt;
        logic [31:0] dt_q16;
        r = '{default: '0};
        case (c.op)
            OP_EMIT: begin
                found = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (found < 0 && !in_use[i]) found = i;
                end
                if (found < 0) begin
                    r.status = 1'b1;
                end else begin
                    pool[found].px = c.px;
                    pool[found].py = c.py;
                    pool[found].vx = c.vx;
                    pool[found].vy = c.vy;
                    pool[found].ax = c.ax;
                    pool[found].ay = c.ay;
                    pool[found].drag = c.drag;
                    pool[found].life = (c.life == 0) ? LIFE_ONE : c.life;
                    pool[found].app = c.app;
                    if (c.app[23:16] == 0) pool[found].app[23:16] = SIZE_ONE;
                    in_use[found] = 1'b1;
                    if (found + 1 > top) top = found + 1;
                    live_cnt++;
                    r.slot = found[5:0];
                end
            end
            OP_TICK: begin
                dt = longint'(c.dt);
                if (dt != 0) begin
                    new_top = 0;
                    dt_q16 = {12'b0, c.dt, 4'b0};
                    for (int i = 0; i < top; i++) begin
                        if (in_use[i]) begin
                            step_particle(i, dt);
                            if (pool[i].life <= dt_q16) begin
                                pool[i].life = '0;
                                in_use[i] = 1'b0;
                                if (live_cnt > 0) live_cnt--;
                            end else begin
                                pool[i].life -= dt_q16;
                                new_top = i + 1;
                            end
                        end
                    end
                    top = new_top;
                end
            end
            OP_CLEAR: wipe_pool();
            default: begin
                r.slot = c.idx;
                r.active = in_use[c.idx];
                r.px = pool[c.idx].px;
                r.py = pool[c.idx].py;
                r.vx = pool[c.idx].vx;
                r.vy = pool[c.idx].vy;
                r.life = pool[c.idx].life;
                r.app = pool[c.idx].app;
            end
        endcase
        r.alive = live_cnt[6:0];
        r.high = top[6:0];
        return r;
    endfunction

    // Offer one transaction and hold it until taken; returns the prediction
    task automatic send_cmd(input t_pool_cmd c, output t_pool_resp r);
        int gap;
        bit stalled;
        gap = calm ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2));
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        op_w <= c.op;
        px_w <= c.px; py_w <= c.py; vx_w <= c.vx; vy_w <= c.vy;
        ax_w <= c.ax; ay_w <= c.ay; drag_w <= c.drag;
        life_w <= c.life; app_w <= c.app; dt_w <= c.dt; idx_w <= c.idx;
        // stall only moves at the rising edge, so the falling edge sees the value it will have
        do begin
            @(negedge i_clk);
            stalled = in_stall;
            @(posedge i_clk);
        end while (stalled);
        r = predict_pool(c);
    endtask

    function automatic t_pool_cmd rand_cmd(input t_op op, input bit long_life);
        t_pool_cmd c;
        c.op = op;
        c.px = $urandom; c.py = $urandom; c.vx = $urandom; c.vy = $urandom;
        c.ax = $urandom; c.ay = $urandom;
        c.drag = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
        if (long_life) c.life = $urandom;
        else if ($urandom_range(0, 7) == 0) c.life = 0;
        else c.life = $urandom_range(1, 32'h8_0000);
        c.app = $urandom;
        if ($urandom_range(0, 7) == 0) c.app[23:16] = 8'h0;
        case ($urandom_range(0, 9))
            0: c.dt = 16'h0;
            1, 2: c.dt = 16'($urandom);
            default: c.dt = 16'($urandom_range(1, 16'h2000));
        endcase
        c.idx = 6'($urandom);
        return c;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %h, got %h", name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        t_pool_resp e;
        hold = 0;
        @(posedge i_rst_n);
        forever begin
            // check the transaction that the coming rising edge will take
            @(negedge i_clk);
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    fail_cnt++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("status", e.status, st);
                    check_field("slot", e.slot, slot_o);
                    check_field("alive_count", e.alive, alive_o);
                    check_field("high_mark", e.high, high_o);
                    check_field("slot_active", e.active, act);
                    check_field("out_pos_x", e.px, opx);
                    check_field("out_pos_y", e.py, opy);
                    check_field("out_vel_x", e.vx, ovx);
                    check_field("out_vel_y", e.vy, ovy);
                    check_field("life_left", e.life, olife);
                    check_field("out_appearance", e.app, oapp);
                end
            end
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                out_stall <= (hold != 0);
            end else if (calm || inputs_done) begin
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 19) == 0) begin
                hold = $urandom_range(10, 60);
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic push_row(input t_table_row row);
        t_pool_resp r;
        send_cmd(row.cmd, r);
        if (row.typed) begin
            r.status = row.status;
            r.slot = row.slot;
            r.alive = row.alive;
            r.high = row.high;
        end
        pending_results.push_back(r);
    endtask

    initial begin
        t_table_row rows[$];
        t_table_row row;
        t_pool_cmd c, zero_cmd;
        t_pool_resp r;
        int sent, burst;
        t_op op;
        bit held;

        wipe_pool();
        held = 1'b0;
        zero_cmd = '{op: OP_CLEAR, default: '0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Clear first so every record row is defined before any read
        row = '{cmd: zero_cmd, typed: 1, status: 0, slot: 0, alive: 0, high: 0};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_EMIT;                      // zero life and zero size
        row = '{cmd: c, typed: 1, status: 0, slot: 0, alive: 1, high: 1};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_READ; c.idx = 0;
        row = '{cmd: c, typed: 0, default: '0}; rows.push_back(row);
        c = '{op: OP_EMIT, px: 32'sh7fffffff, py: 32'sh7fffffff, vx: 32'sh7fffffff,
              vy: 32'sh7fffffff, ax: 32'sh7fffffff, ay: 32'sh7fffffff, drag: 16'hffff,
              life: 32'hffffffff, app: 32'hffffffff, dt: 16'hffff, idx: 6'h3f};
        row = '{cmd: c, typed: 1, status: 0, slot: 1, alive: 2, high: 2};
        rows.push_back(row);
        c = '{op: OP_EMIT, px: 32'sh80000000, py: 32'sh80000000, vx: 32'sh80000000,
              vy: 32'sh80000000, ax: 32'sh80000000, ay: 32'sh80000000, drag: 16'h0,
              life: 32'h1, app: 32'h0, dt: 16'h0, idx: 6'h0};
        row = '{cmd: c, typed: 1, status: 0, slot: 2, alive: 3, high: 3};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_TICK;                      // zero step does nothing
        row = '{cmd: c, typed: 1, status: 0, slot: 0, alive: 3, high: 3};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_TICK; c.dt = 16'hffff;     // expires slots 0 and 2
        row = '{cmd: c, typed: 1, status: 0, slot: 0, alive: 1, high: 2};
        rows.push_back(row);
        for (int s = 0; s < 3; s++) begin
            c = zero_cmd; c.op = OP_READ; c.idx = s[5:0];
            row = '{cmd: c, typed: 0, default: '0}; rows.push_back(row);
        end
        c = zero_cmd; c.op = OP_EMIT; c.vx = 32'sh0001_0000; c.ax = -32'sh0002_0000;
        c.drag = 16'h0100; c.life = 32'h0004_0000;
        row = '{cmd: c, typed: 1, status: 0, slot: 0, alive: 2, high: 2};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_TICK; c.dt = 16'h1;
        row = '{cmd: c, typed: 0, default: '0}; rows.push_back(row);
        c = zero_cmd; c.op = OP_READ; c.idx = 0;
        row = '{cmd: c, typed: 0, default: '0}; rows.push_back(row);
        row = '{cmd: zero_cmd, typed: 1, status: 0, slot: 0, alive: 0, high: 0};
        rows.push_back(row);
        c = zero_cmd; c.op = OP_READ; c.idx = 6'h3f;
        row = '{cmd: c, typed: 1, status: 0, slot: 63, alive: 0, high: 0};
        rows.push_back(row);

        foreach (rows[k]) push_row(rows[k]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(0, 9);
            calm = ($urandom_range(0, 5) == 0);
            if (!held && sent >= 300) begin
                hold_req = 1'b1;
                held = 1'b1;
            end
            if (sent > 900 && sent < 1000) begin
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (burst == 0) begin
                // fill the pool past full, then look at it
                for (int k = 0; k < 68; k++) begin
                    send_cmd(rand_cmd(OP_EMIT, 1), r);
                    pending_results.push_back(r);
                end
                for (int k = 0; k < 6; k++) begin
                    send_cmd(rand_cmd(($urandom_range(0, 1) == 0) ? OP_READ : OP_TICK, 0), r);
                    pending_results.push_back(r);
                end
                send_cmd(rand_cmd(OP_CLEAR, 0), r);
                pending_results.push_back(r);
                sent += 75;
            end else begin
                for (int k = 0; k < 20; k++) begin
                    case ($urandom_range(0, 19))
                        0: op = OP_CLEAR;
                        1, 2, 3, 4, 5: op = OP_TICK;
                        6, 7, 8, 9, 10, 11: op = OP_READ;
                        default: op = OP_EMIT;
                    endcase
                    send_cmd(rand_cmd(op, $urandom_range(0, 9) == 0), r);
                    pending_results.push_back(r);
                end
                sent += 20;
            end
        end
        in_valid <= 1'b0;
        inputs_done = 1'b1;
        calm = 1'b1;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #80000000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
design/ppi_pkg.sv
design/ppi_ram.sv
design/ppi_mul.sv
design/particle_pool_integrator.sv
tb/sv/testbench.sv
